FILE: hdl/mlt_pkg.sv
`timescale 1ns / 1ps

package mlt_pkg;

  localparam int ADDR_W = 48;
  localparam int PORT_W = 4;
  localparam int AGE_W  = 16;
  localparam int CNT_W  = 7;
  localparam int KIND_W = 2;

  localparam logic [AGE_W-1:0] AGE_MAX       = '1;
  localparam logic [AGE_W-1:0] AGE_LIMIT_RST = AGE_W'(30);
  localparam logic [CNT_W-1:0] CNT_MAX       = '1;

  typedef enum logic [KIND_W-1:0] {
    KIND_LOOKUP = 2'd0,
    KIND_LEARN  = 2'd1,
    KIND_TICK   = 2'd2,
    KIND_NONE   = 2'd3
  } kind_e;

  typedef struct packed {
    logic              valid;
    logic [ADDR_W-1:0] addr;
    logic [PORT_W-1:0] port;
    logic [AGE_W-1:0]  age;
  } entry_t;

  typedef struct packed {
    logic   match;
    logic   free;
    logic   expire;
    entry_t aged;
  } unit_res_t;

endpackage

FILE: hdl/mac_learning_table.sv
`timescale 1ns / 1ps

// Station address table with learning and aging.
// Command channel: kind_i, mac_addr_i and port_in_i are taken at a rising edge with start
// high and busy low. kind 0 looks up an address, 1 learns address to port, 2 is a
// one-second tick that ages every entry and removes those past the age limit.
// Each command sweeps all ENTRIES slots through one shared compare/age unit, one slot
// per cycle from a table memory with a read port, a write port and registered read data.
// After the sweep the DONE state registers the result beat, held on hit_o, port_out_o,
// table_full_o and removed_count_o for exactly one cycle with result_valid_o high;
// busy is low in that cycle, so the next command can already be taken in it.
// The receiver cannot stall: every result beat is taken in its cycle.
// The age limit is written through cfg_valid_i/cfg_data_i (cfg_ready_o is always high);
// the user must do so only with no command in flight (not enforced); it resets to 30.
// After reset the table is swept clear, one slot per cycle over all ENTRIES slots; busy
// stays high for that sweep and no command is taken.
module mac_learning_table
  import mlt_pkg::*;
#(
  parameter int ENTRIES = 64,
  parameter int PORTS   = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  logic [KIND_W-1:0] kind_i,
  input  logic [ADDR_W-1:0] mac_addr_i,
  input  logic [PORT_W-1:0] port_in_i,
  output logic              result_valid_o,
  output logic              hit_o,
  output logic [PORT_W-1:0] port_out_o,
  output logic              table_full_o,
  output logic [CNT_W-1:0]  removed_count_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [AGE_W-1:0]  cfg_data_i
);

  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam logic [IW-1:0] LAST_IDX = IW'(ENTRIES - 1);
  localparam logic [IW:0]   NUM_ENT  = (IW + 1)'(ENTRIES);

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_SCAN  = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  entry_t mem [ENTRIES];

  logic [1:0]        state_q, state_d;
  logic [IW:0]       iss_q, iss_d;
  logic              rd_vld_q;
  logic [IW-1:0]     rd_idx_q;
  logic [IW-1:0]     clr_q, clr_d;
  entry_t            rd_data_q;
  kind_e             kind_q;
  logic [ADDR_W-1:0] addr_q;
  logic [PORT_W-1:0] port_q;
  logic              found_q, found_d;
  logic [IW-1:0]     found_idx_q, found_idx_d;
  logic [PORT_W-1:0] found_port_q, found_port_d;
  logic              free_q, free_d;
  logic [IW-1:0]     free_idx_q, free_idx_d;
  logic [CNT_W-1:0]  rem_q, rem_d;
  logic [AGE_W-1:0]  age_limit_q;
  logic              valid_q;
  logic              hit_q;
  logic [PORT_W-1:0] pout_q;
  logic              full_q;
  logic [CNT_W-1:0]  cnt_q;

  logic              rd_en;
  logic              wr_en;
  logic [IW-1:0]     wr_addr;
  entry_t            wr_data;
  logic              accept;
  logic              port_ok;
  logic              learn_wr;
  unit_res_t         unit_res;

  mlt_entry_unit u_unit (
    .entry_i     (rd_data_q),
    .key_i       (addr_q),
    .age_limit_i (age_limit_q),
    .res_o       (unit_res)
  );

  assign busy        = (state_q != ST_IDLE);
  assign accept      = start && !busy;
  assign cfg_ready_o = 1'b1;
  assign rd_en       = (state_q == ST_SCAN) && (iss_q < NUM_ENT);
  assign port_ok     = 32'(port_q) < PORTS;
  assign learn_wr    = (kind_q == KIND_LEARN) && port_ok && (found_q || free_q);

  always_comb begin
    state_d      = state_q;
    iss_d        = iss_q;
    clr_d        = clr_q;
    found_d      = found_q;
    found_idx_d  = found_idx_q;
    found_port_d = found_port_q;
    free_d       = free_q;
    free_idx_d   = free_idx_q;
    rem_d        = rem_q;
    wr_en        = 1'b0;
    wr_addr      = clr_q;
    wr_data      = '0;
    case (state_q)
      ST_CLEAR: begin
        wr_en = 1'b1;
        clr_d = clr_q + IW'(1);
        if (clr_q == LAST_IDX) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_SCAN;
          iss_d   = '0;
          found_d = 1'b0;
          free_d  = 1'b0;
          rem_d   = '0;
        end
      end
      ST_SCAN: begin
        if (rd_en) begin
          iss_d = iss_q + (IW + 1)'(1);
        end
        if (rd_vld_q) begin
          if (unit_res.match && !found_q) begin
            found_d      = 1'b1;
            found_idx_d  = rd_idx_q;
            found_port_d = rd_data_q.port;
          end
          if (unit_res.free && !free_q) begin
            free_d     = 1'b1;
            free_idx_d = rd_idx_q;
          end
          if (kind_q == KIND_TICK && rd_data_q.valid) begin
            wr_en   = 1'b1;
            wr_addr = rd_idx_q;
            wr_data = unit_res.aged;
            if (unit_res.expire && rem_q != CNT_MAX) begin
              rem_d = rem_q + CNT_W'(1);
            end
          end
          if (rd_idx_q == LAST_IDX) begin
            state_d = ST_DONE;
          end
        end
      end
      ST_DONE: begin
        state_d = ST_IDLE;
        if (learn_wr) begin
          wr_en         = 1'b1;
          wr_addr       = found_q ? found_idx_q : free_idx_q;
          wr_data.valid = 1'b1;
          wr_data.addr  = addr_q;
          wr_data.port  = port_q;
          wr_data.age   = '0;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_q <= mem[iss_q[IW-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      iss_q       <= '0;
      rd_vld_q    <= 1'b0;
      clr_q       <= '0;
      found_q     <= 1'b0;
      free_q      <= 1'b0;
      rem_q       <= '0;
      age_limit_q <= AGE_LIMIT_RST;
      valid_q     <= 1'b0;
    end else begin
      state_q  <= state_d;
      iss_q    <= iss_d;
      rd_vld_q <= rd_en;
      clr_q    <= clr_d;
      found_q  <= found_d;
      free_q   <= free_d;
      rem_q    <= rem_d;
      valid_q  <= (state_q == ST_DONE);
      if (cfg_valid_i && cfg_ready_o) begin
        age_limit_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rd_idx_q     <= iss_q[IW-1:0];
    found_idx_q  <= found_idx_d;
    found_port_q <= found_port_d;
    free_idx_q   <= free_idx_d;
    if (accept) begin
      kind_q <= kind_e'(kind_i);
      addr_q <= mac_addr_i;
      port_q <= port_in_i;
    end
    if (state_q == ST_DONE) begin
      hit_q  <= (kind_q == KIND_LOOKUP) && found_q;
      pout_q <= ((kind_q == KIND_LOOKUP) && found_q) ? found_port_q : '0;
      full_q <= (kind_q == KIND_LEARN) && port_ok && !found_q && !free_q;
      cnt_q  <= (kind_q == KIND_TICK) ? rem_q : '0;
    end
  end

  assign result_valid_o  = valid_q;
  assign hit_o           = hit_q;
  assign port_out_o      = pout_q;
  assign table_full_o    = full_q;
  assign removed_count_o = cnt_q;

`ifndef SYNTHESIS
  a_beat_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("result beat longer than one cycle");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (busy && !result_valid_o))
    else $error("command accepted without going busy");

  a_hit_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && hit_o) |-> (!table_full_o && removed_count_o == '0))
    else $error("lookup hit mixed with learn or tick result");

  a_done_then_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE) |=> (result_valid_o && !busy))
    else $error("result beat missing after sweep");
`endif

endmodule

FILE: hdl/mlt_entry_unit.sv
`timescale 1ns / 1ps

module mlt_entry_unit
  import mlt_pkg::*;
(
  input  entry_t            entry_i,
  input  logic [ADDR_W-1:0] key_i,
  input  logic [AGE_W-1:0]  age_limit_i,
  output unit_res_t         res_o
);

  logic [AGE_W-1:0] age_next;

  always_comb begin
    age_next = (entry_i.age == AGE_MAX) ? entry_i.age : entry_i.age + AGE_W'(1);
    res_o.match  = entry_i.valid && (entry_i.addr == key_i);
    res_o.free   = !entry_i.valid;
    res_o.expire = entry_i.valid && (age_next > age_limit_i);
    res_o.aged.valid = entry_i.valid && !(age_next > age_limit_i);
    res_o.aged.addr  = entry_i.addr;
    res_o.aged.port  = entry_i.port;
    res_o.aged.age   = age_next;
  end

endmodule

FILE: tb/tb_mac_learning_table.sv
`timescale 1ns / 1ps

module tb_mac_learning_table
  import mlt_pkg::*;
();

  localparam int NUM_ENTRIES   = 64;
  localparam int NUM_PORTS     = 16;
  localparam int CLK_HALF      = 6;
  localparam int RST_CYCLES    = 8;
  localparam int ITEM_LATENCY  = NUM_ENTRIES + 3;
  localparam int CYCLE_LIMIT   = 2000000;
  localparam int NUM_PHASES    = 6;
  localparam int ITEMS_PER_PH  = 296;
  localparam int POOL_SIZE     = 80;
  localparam int NUM_DIRECTED  = 22;

  localparam logic [ADDR_W-1:0] ADDR_ONES = '1;
  localparam logic [ADDR_W-1:0] ADDR_MID  = 48'h0123_4567_89AB;
  localparam logic [ADDR_W-1:0] ADDR_AAAA = 48'hAAAA_AAAA_AAAA;
  localparam logic [ADDR_W-1:0] ADDR_5555 = 48'h5555_5555_5555;

  typedef struct packed {
    logic              hit;
    logic [PORT_W-1:0] port;
    logic              full;
    logic [CNT_W-1:0]  removed;
  } outcome_t;

  typedef struct packed {
    kind_e             kind;
    logic [ADDR_W-1:0] addr;
    logic [PORT_W-1:0] port;
    logic              typed;
    outcome_t          want;
  } dir_row_t;

  localparam outcome_t NO_OUT = '0;

  localparam dir_row_t DIRECTED[NUM_DIRECTED] = '{
    '{KIND_LOOKUP, 48'h0,          4'h0, 1'b1, NO_OUT},
    '{KIND_LOOKUP, ADDR_ONES,      4'h0, 1'b1, NO_OUT},
    '{KIND_TICK,   48'h0,          4'h0, 1'b1, NO_OUT},
    '{KIND_NONE,   ADDR_ONES,      4'hF, 1'b1, NO_OUT},
    '{KIND_LEARN,  48'h0,          4'h0, 1'b1, NO_OUT},
    '{KIND_LEARN,  ADDR_ONES,      4'hF, 1'b1, NO_OUT},
    '{KIND_LOOKUP, 48'h0,          4'h0, 1'b1, '{1'b1, 4'h0, 1'b0, 7'd0}},
    '{KIND_LOOKUP, ADDR_ONES,      4'h0, 1'b1, '{1'b1, 4'hF, 1'b0, 7'd0}},
    '{KIND_LOOKUP, 48'h1,          4'h0, 1'b1, NO_OUT},
    '{KIND_LOOKUP, 48'h8000_0000_0000, 4'h0, 1'b1, NO_OUT},
    '{KIND_LEARN,  ADDR_ONES,      4'h5, 1'b1, NO_OUT},
    '{KIND_LOOKUP, ADDR_ONES,      4'h0, 1'b1, '{1'b1, 4'h5, 1'b0, 7'd0}},
    '{KIND_LEARN,  ADDR_MID,       4'hA, 1'b0, NO_OUT},
    '{KIND_TICK,   48'h0,          4'h0, 1'b0, NO_OUT},
    '{KIND_LOOKUP, ADDR_MID,       4'h0, 1'b0, NO_OUT},
    '{KIND_NONE,   ADDR_MID,       4'h0, 1'b1, NO_OUT},
    '{KIND_LOOKUP, ADDR_MID,       4'h0, 1'b0, NO_OUT},
    '{KIND_LEARN,  ADDR_AAAA,      4'h9, 1'b0, NO_OUT},
    '{KIND_LEARN,  ADDR_5555,      4'h6, 1'b0, NO_OUT},
    '{KIND_TICK,   48'h0,          4'h0, 1'b0, NO_OUT},
    '{KIND_LOOKUP, ADDR_5555,      4'h0, 1'b0, NO_OUT},
    '{KIND_LEARN,  ADDR_MID,       4'h3, 1'b0, NO_OUT}
  };

  logic              clk_i;
  logic              rst_ni;
  logic              start;
  logic              busy;
  logic [KIND_W-1:0] kind_i;
  logic [ADDR_W-1:0] mac_addr_i;
  logic [PORT_W-1:0] port_in_i;
  logic              result_valid_o;
  logic              hit_o;
  logic [PORT_W-1:0] port_out_o;
  logic              table_full_o;
  logic [CNT_W-1:0]  removed_count_o;
  logic              cfg_valid_i;
  logic              cfg_ready_o;
  logic [AGE_W-1:0]  cfg_data_i;

  // shadow of the table
  logic              shadow_valid[NUM_ENTRIES];
  logic [ADDR_W-1:0] shadow_addr[NUM_ENTRIES];
  logic [PORT_W-1:0] shadow_port[NUM_ENTRIES];
  logic [AGE_W-1:0]  shadow_age[NUM_ENTRIES];
  logic [AGE_W-1:0]  shadow_limit;

  outcome_t          outcome_q[$];
  logic [ADDR_W-1:0] addr_pool[POOL_SIZE];
  int unsigned       err_cnt;
  int unsigned       cycle_cnt;

  mac_learning_table #(
    .ENTRIES(NUM_ENTRIES),
    .PORTS  (NUM_PORTS)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .kind_i         (kind_i),
    .mac_addr_i     (mac_addr_i),
    .port_in_i      (port_in_i),
    .result_valid_o (result_valid_o),
    .hit_o          (hit_o),
    .port_out_o     (port_out_o),
    .table_full_o   (table_full_o),
    .removed_count_o(removed_count_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i)
  );

  initial clk_i = 1'b0;
  always #(CLK_HALF) clk_i = ~clk_i;

  function automatic int find_shadow(logic [ADDR_W-1:0] addr);
    for (int i = 0; i < NUM_ENTRIES; i++) begin
      if (shadow_valid[i] && shadow_addr[i] == addr) return i;
    end
    return -1;
  endfunction

  function automatic outcome_t apply_table_cmd(kind_e kind, logic [ADDR_W-1:0] addr,
                                               logic [PORT_W-1:0] port);
    outcome_t res;
    int       slot;
    res = '0;
    case (kind)
      KIND_LOOKUP: begin
        slot = find_shadow(addr);
        if (slot >= 0) begin
          res.hit  = 1'b1;
          res.port = shadow_port[slot];
        end
      end
      KIND_LEARN: begin
        if (int'(port) < NUM_PORTS) begin
          slot = find_shadow(addr);
          if (slot < 0) begin
            for (int i = 0; i < NUM_ENTRIES; i++) begin
              if (!shadow_valid[i]) begin
                slot = i;
                break;
              end
            end
          end
          if (slot < 0) begin
            res.full = 1'b1;
          end else begin
            shadow_valid[slot] = 1'b1;
            shadow_addr[slot]  = addr;
            shadow_port[slot]  = port;
            shadow_age[slot]   = '0;
          end
        end
      end
      KIND_TICK: begin
        for (int i = 0; i < NUM_ENTRIES; i++) begin
          if (shadow_valid[i]) begin
            if (shadow_age[i] != AGE_MAX) shadow_age[i] = shadow_age[i] + 1'b1;
            if (shadow_age[i] > shadow_limit) begin
              shadow_valid[i] = 1'b0;
              if (res.removed != CNT_MAX) res.removed = res.removed + 1'b1;
            end
          end
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      err_cnt++;
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk_i) begin
    outcome_t want;
    if (rst_ni && result_valid_o) begin
      if (outcome_q.size() == 0) begin
        err_cnt++;
        $display("%0t: result beat with none expected, expected none actual %b/%0h/%b/%0d",
                 $time, hit_o, port_out_o, table_full_o, removed_count_o);
      end else begin
        want = outcome_q.pop_front();
        check_field("hit", 32'(want.hit), 32'(hit_o));
        check_field("port_out", 32'(want.port), 32'(port_out_o));
        check_field("table_full", 32'(want.full), 32'(table_full_o));
        check_field("removed_count", 32'(want.removed), 32'(removed_count_o));
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic send_cmd(kind_e kind, logic [ADDR_W-1:0] addr, logic [PORT_W-1:0] port,
                          int unsigned idle_pct, logic typed, outcome_t want);
    outcome_t pred;
    @(negedge clk_i);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 100)) @(negedge clk_i);
    end
    start      <= 1'b1;
    kind_i     <= kind;
    mac_addr_i <= addr;
    port_in_i  <= port;
    do @(posedge clk_i); while (busy);
    pred = apply_table_cmd(kind, addr, port);
    outcome_q.push_back(typed ? want : pred);
  endtask

  task automatic wait_table_idle();
    @(negedge clk_i);
    start <= 1'b0;
    do @(posedge clk_i); while (outcome_q.size() != 0 || busy);
  endtask

  task automatic write_age_limit(logic [AGE_W-1:0] value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    shadow_limit = value;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [ADDR_W-1:0] random_addr();
    logic [ADDR_W-1:0] a;
    a = {16'($urandom), 32'($urandom)};
    case ($urandom_range(7))
      0: a = '0;
      1: a = ADDR_ONES;
      default: ;
    endcase
    return a;
  endfunction

  initial begin
    int unsigned       phase_limit[NUM_PHASES];
    int unsigned       tick_pct[NUM_PHASES];
    int unsigned       idle_pct;
    int unsigned       r;
    kind_e             kind;
    logic [ADDR_W-1:0] addr;

    phase_limit = '{1, 65535, 0, 3, 0, 30};
    tick_pct    = '{20, 4, 20, 20, 20, 15};
    rst_ni      = 1'b0;
    start       = 1'b0;
    kind_i      = KIND_LOOKUP;
    mac_addr_i  = '0;
    port_in_i   = '0;
    cfg_valid_i = 1'b0;
    cfg_data_i  = '0;
    shadow_limit = AGE_LIMIT_RST;
    for (int i = 0; i < NUM_ENTRIES; i++) begin
      shadow_valid[i] = 1'b0;
      shadow_addr[i]  = '0;
      shadow_port[i]  = '0;
      shadow_age[i]   = '0;
    end
    for (int i = 0; i < POOL_SIZE; i++) addr_pool[i] = {16'($urandom), 32'($urandom)};
    addr_pool[0] = '0;
    addr_pool[1] = ADDR_ONES;

    repeat (RST_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (DIRECTED[i]) begin
      send_cmd(DIRECTED[i].kind, DIRECTED[i].addr, DIRECTED[i].port, 0,
               DIRECTED[i].typed, DIRECTED[i].want);
    end

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      wait_table_idle();
      write_age_limit(ph == 4 ? AGE_W'($urandom_range(4, 400)) : AGE_W'(phase_limit[ph]));
      idle_pct = (ph < 2) ? 33 : (ph < 4) ? 53 : 0;
      for (int n = 0; n < ITEMS_PER_PH; n++) begin
        r = $urandom_range(99);
        if (r < tick_pct[ph])          kind = KIND_TICK;
        else if (r < tick_pct[ph] + 5)  kind = KIND_NONE;
        else if (r < tick_pct[ph] + 40) kind = KIND_LOOKUP;
        else                            kind = KIND_LEARN;
        addr = ($urandom_range(99) < 80) ? addr_pool[$urandom_range(POOL_SIZE - 1)]
                                         : random_addr();
        if ($urandom_range(99) < 2) wait_table_idle();
        send_cmd(kind, addr, PORT_W'($urandom_range(15)), idle_pct, 1'b0, NO_OUT);
      end
    end

    wait_table_idle();
    repeat (ITEM_LATENCY + 10) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
